// ----- rtl/core/crc16_configurable_bit_order_core_macros.svh -----
// assertion macros used by the checker of the crc16 core
`ifndef CRC16_CONFIGURABLE_BIT_ORDER_CORE_MACROS_SVH
`define CRC16_CONFIGURABLE_BIT_ORDER_CORE_MACROS_SVH

// same-cycle implication, checked outside reset
`define CRC16CBO_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define CRC16CBO_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// next-cycle implication, also checked while reset is applied
`define CRC16CBO_ASSERT_RST(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/crc16cbo_pkg.sv -----
package crc16cbo_pkg;

  localparam int unsigned CRC_W    = 16;
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CRC_W-1:0] POLY_RST  = 16'h1021;
  localparam logic [CRC_W-1:0] START_RST = 16'h0000;
  localparam logic             ORDER_RST = 1'b1;
  localparam logic [CRC_W-1:0] REM_RST   = 16'h0000;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_POLY  = 2'd0,
    CFG_START = 2'd1,
    CFG_ORDER = 2'd2
  } cfg_idx_t;

  // live configuration handed to the fold logic
  typedef struct packed {
    logic [CRC_W-1:0] poly;
    logic             msb_first;
  } crc_cfg_t;

endpackage

// ----- rtl/core/crc16cbo_fold.sv -----
module crc16cbo_fold (
  input  crc16cbo_pkg::crc_cfg_t          cfg,
  input  logic [crc16cbo_pkg::BYTE_W-1:0] data_byte,
  input  logic [crc16cbo_pkg::CRC_W-1:0]  crc_in,
  output logic [crc16cbo_pkg::CRC_W-1:0]  crc_out
);
  import crc16cbo_pkg::*;

  // eight shift/xor steps, direction chosen by the bit order
  always_comb begin
    logic [CRC_W-1:0] crc;
    crc = crc_in;
    if (cfg.msb_first) begin
      crc = crc ^ {data_byte, {(CRC_W-BYTE_W){1'b0}}};
      for (int k = 0; k < BYTE_W; k++) begin
        if (crc[CRC_W-1]) begin
          crc = {crc[CRC_W-2:0], 1'b0} ^ cfg.poly;
        end else begin
          crc = {crc[CRC_W-2:0], 1'b0};
        end
      end
    end else begin
      crc = crc ^ {{(CRC_W-BYTE_W){1'b0}}, data_byte};
      for (int k = 0; k < BYTE_W; k++) begin
        if (crc[0]) begin
          crc = {1'b0, crc[CRC_W-1:1]} ^ cfg.poly;
        end else begin
          crc = {1'b0, crc[CRC_W-1:1]};
        end
      end
    end
    crc_out = crc;
  end

endmodule

// ----- rtl/core/crc16_configurable_bit_order_core.sv -----
// byte-serial crc16 with programmable polynomial, start value and bit order
// a request passes through an input register and a result register on its way to the result
// throughput: one byte per cycle while the result side is not stalled; the eight-step fold is one combinational pass
// the remainder feeds back from the fold output, so back-to-back bytes chain directly
// reset (rst_n low, synchronous): pipeline empties, remainder 0, registers to defaults
module crc16_configurable_bit_order_core (
  input  logic                                clk,
  input  logic                                rst_n,
  // configuration write port
  input  logic                                cfg_we,
  input  logic [crc16cbo_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [crc16cbo_pkg::CFG_DATA_W-1:0] cfg_wdata,
  // input stream
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [7:0]                          in_tdata,  // [7:0] data_byte
  input  logic                                in_tuser,  // [0] first_byte
  input  logic                                in_tlast,  // last_byte
  // result stream
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [15:0]                         out_tdata, // [15:0] crc_value
  output logic                                out_tlast  // is_final
);
  import crc16cbo_pkg::*;

  logic [CRC_W-1:0]  poly_r, start_r, rem_r;
  logic              order_r;
  logic              s1_valid_r, out_valid_r;
  logic [BYTE_W-1:0] s1_byte_r;
  logic              s1_first_r, s1_last_r;
  logic [CRC_W-1:0]  out_crc_r;
  logic              out_last_r;
  logic              advance;
  logic [CRC_W-1:0]  fold_in, fold_out;
  crc_cfg_t          cfg;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      poly_r  <= POLY_RST;
      start_r <= START_RST;
      order_r <= ORDER_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_POLY:  poly_r  <= cfg_wdata[CRC_W-1:0];
        CFG_START: start_r <= cfg_wdata[CRC_W-1:0];
        CFG_ORDER: order_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // handshake: the input stage moves on when the result slot is free or drains
  assign advance   = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || advance;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_byte_r  <= in_tdata;
      s1_first_r <= in_tuser;
      s1_last_r  <= in_tlast;
    end
  end

  // fold one byte onto the start value or the running remainder
  assign cfg.poly      = poly_r;
  assign cfg.msb_first = order_r;
  assign fold_in       = s1_first_r ? start_r : rem_r;

  crc16cbo_fold u_fold (
    .cfg       (cfg),
    .data_byte (s1_byte_r),
    .crc_in    (fold_in),
    .crc_out   (fold_out)
  );

  // running remainder and result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r       <= REM_RST;
      out_valid_r <= 1'b0;
    end else begin
      if (advance) begin
        rem_r <= fold_out;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (advance) begin
      out_crc_r  <= fold_out;
      out_last_r <= s1_last_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_crc_r;
  assign out_tlast  = out_last_r;

endmodule

// ----- rtl/core/crc16cbo_checker.sv -----
`include "crc16_configurable_bit_order_core_macros.svh"

module crc16cbo_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata,
  input logic        out_tlast
);

  // a stalled result stays offered
  `CRC16CBO_ASSERT_NXT(a_out_hold, out_tvalid && !out_tready, out_tvalid, "result dropped")

  // a stalled result keeps its payload
  `CRC16CBO_ASSERT_NXT(a_out_stable, out_tvalid && !out_tready,
                       $stable(out_tdata) && $stable(out_tlast), "result changed while stalled")

  // the input side only stalls when the result slot is occupied
  `CRC16CBO_ASSERT_IMP(a_ready_when_empty, !out_tvalid, in_tready, "input stalled, output empty")

  // reset leaves the pipeline empty and ready for a request
  `CRC16CBO_ASSERT_RST(a_reset_empty, !rst_n, !out_tvalid && in_tready, "not empty after reset")

endmodule

bind crc16_configurable_bit_order_core crc16cbo_checker u_crc16cbo_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);

// ----- tb/sv/crc16_configurable_bit_order_core_tb.sv -----
module crc16_configurable_bit_order_core_tb;
  import crc16cbo_pkg::*;

  localparam int unsigned  CYCLE_LIMIT = 300000;
  localparam int unsigned  PHASE_BYTES = 50;
  localparam int unsigned  RAND_PHASES = 10;
  localparam int unsigned  SPLIT_ROW   = 13;
  localparam int unsigned  DIR_ROWS    = 24;
  localparam int unsigned  DRAIN_WAIT  = 4;
  // no register sits at this index, writes to it must be dropped
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  // one directed request, with a hand-computed crc where it is obvious
  typedef struct packed {
    logic [7:0]  data;
    logic        first;
    logic        last;
    logic        known;
    logic [15:0] crc;
  } crc_row_t;

  // one expected result
  typedef struct packed {
    logic [15:0] crc;
    logic        is_final;
  } crc_result_t;

  localparam crc_row_t DIRECTED [0:DIR_ROWS-1] = '{
    // default setup: poly 0x1021, start 0, msb first
    '{8'h00, 1'b0, 1'b0, 1'b1, 16'h0000},  // no start byte since reset
    '{8'hFF, 1'b0, 1'b0, 1'b0, 16'h0000},
    '{8'h01, 1'b1, 1'b1, 1'b1, 16'h1021},  // one-byte message
    '{8'h80, 1'b0, 1'b1, 1'b0, 16'h0000},  // keeps folding after a last byte
    '{8'h31, 1'b1, 1'b0, 1'b0, 16'h0000},
    '{8'h32, 1'b0, 1'b0, 1'b0, 16'h0000},
    '{8'h33, 1'b0, 1'b0, 1'b0, 16'h0000},
    '{8'h34, 1'b0, 1'b0, 1'b0, 16'h0000},
    '{8'h35, 1'b0, 1'b0, 1'b0, 16'h0000},
    '{8'h36, 1'b0, 1'b0, 1'b0, 16'h0000},
    '{8'h37, 1'b0, 1'b0, 1'b0, 16'h0000},
    '{8'h38, 1'b0, 1'b0, 1'b0, 16'h0000},
    '{8'h39, 1'b0, 1'b1, 1'b1, 16'h31C3},  // standard check string
    // reflected setup: poly 0x8408, start 0xffff, lsb first
    '{8'h31, 1'b1, 1'b0, 1'b0, 16'h0000},
    '{8'h32, 1'b0, 1'b0, 1'b0, 16'h0000},
    '{8'h33, 1'b0, 1'b0, 1'b0, 16'h0000},
    '{8'h34, 1'b0, 1'b0, 1'b0, 16'h0000},
    '{8'h35, 1'b0, 1'b0, 1'b0, 16'h0000},
    '{8'h36, 1'b0, 1'b0, 1'b0, 16'h0000},
    '{8'h37, 1'b0, 1'b0, 1'b0, 16'h0000},
    '{8'h38, 1'b0, 1'b0, 1'b0, 16'h0000},
    '{8'h39, 1'b0, 1'b1, 1'b1, 16'h6F91},  // standard check string
    '{8'hFF, 1'b1, 1'b1, 1'b1, 16'h00FF},  // byte cancels the low half
    '{8'h00, 1'b0, 1'b0, 1'b0, 16'h0000}
  };

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [7:0]            in_tdata = '0;
  logic                  in_tuser = 1'b0;
  logic                  in_tlast = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [15:0]           out_tdata;
  logic                  out_tlast;

  // predictor copy of the registers and the running remainder
  logic [15:0] model_poly = POLY_RST;
  logic [15:0] model_start = START_RST;
  logic        model_msb_first = ORDER_RST;
  logic [15:0] model_remainder = REM_RST;

  crc_result_t crc_queue[$];
  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;
  int unsigned burst_left = 1;
  logic [15:0] ready_pattern = 16'hFFFF;
  logic [5:0]  ready_tick = '0;

  crc16_configurable_bit_order_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // eight shift/xor steps in the currently selected bit order
  function automatic logic [15:0] fold_crc_byte(logic [15:0] seed, logic [7:0] data);
    logic [15:0] r;
    r = seed;
    if (model_msb_first) begin
      r = r ^ {data, 8'h00};
      for (int k = 0; k < 8; k++) begin
        if (r[15]) r = (r << 1) ^ model_poly;
        else r = r << 1;
      end
    end else begin
      r = r ^ {8'h00, data};
      for (int k = 0; k < 8; k++) begin
        if (r[0]) r = (r >> 1) ^ model_poly;
        else r = r >> 1;
      end
    end
    return r;
  endfunction

  // send one request and queue the crc it should produce
  task automatic push_byte(input logic [7:0] data, input logic first, input logic last,
                           input logic known, input logic [15:0] known_crc);
    crc_result_t res;
    in_tvalid <= 1'b1;
    in_tdata  <= data;
    in_tuser  <= first;
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    model_remainder = fold_crc_byte(first ? model_start : model_remainder, data);
    res.crc      = known ? known_crc : model_remainder;
    res.is_final = last;
    crc_queue.push_back(res);
  endtask

  // bursts of random length separated by random gaps, junk on the bus while idle
  task automatic pace_sender();
    int unsigned gap;
    burst_left--;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
      if (gap != 0) begin
        in_tvalid <= 1'b0;
        in_tdata  <= $urandom;
        in_tuser  <= $urandom;
        in_tlast  <= $urandom;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // wait until every queued result is back and the pipeline is empty
  task automatic drain();
    in_tvalid <= 1'b0;
    while (crc_queue.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic apply_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] value);
    case (idx)
      CFG_POLY:  model_poly = value;
      CFG_START: model_start = value;
      CFG_ORDER: model_msb_first = value[0];
      default: ;
    endcase
  endtask

  // write all registers back to back, plus a stray write to the unused index
  task automatic configure(input logic [15:0] poly, input logic [15:0] start,
                           input logic [15:0] order);
    logic [CFG_IDX_W-1:0] idx_seq [4];
    logic [15:0]          val_seq [4];
    idx_seq = '{CFG_POLY, CFG_START, CFG_ORDER, CFG_UNUSED};
    val_seq = '{poly, start, order, 16'($urandom)};
    for (int i = 0; i < 4; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= idx_seq[i];
      cfg_wdata <= val_seq[i];
      @(posedge clk);
      apply_reg(idx_seq[i], val_seq[i]);
    end
    cfg_we <= 1'b0;
  endtask

  // receiver stalls on a rotating pattern that is swapped each time the tick counter wraps
  always @(posedge clk) begin
    ready_tick <= ready_tick + 1'b1;
    if (ready_tick == 6'd63) begin
      case ($urandom_range(0, 3))
        0: ready_pattern <= 16'hFFFF;
        1: ready_pattern <= 16'($urandom | $urandom);
        default: ready_pattern <= 16'($urandom);
      endcase
    end else begin
      ready_pattern <= {ready_pattern[0], ready_pattern[15:1]};
    end
    out_tready <= ready_pattern[0];
  end

  // compare each result with the oldest expected one
  always @(posedge clk) begin
    crc_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (crc_queue.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result: crc %h final %b", out_tdata, out_tlast);
      end else begin
        want = crc_queue.pop_front();
        if (out_tdata !== want.crc || out_tlast !== want.is_final) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("result mismatch: crc exp %h got %h, final exp %b got %b",
                     want.crc, out_tdata, want.is_final, out_tlast);
        end
      end
    end
  end

  // hard stop if the stream hangs
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    logic [15:0] poly;
    logic [15:0] start;
    logic [15:0] order;
    logic [7:0]  data;
    int unsigned sent;
    int unsigned len;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // directed rows, switching to the reflected setup at row SPLIT_ROW
    for (int i = 0; i < DIR_ROWS; i++) begin
      if (i == SPLIT_ROW) begin
        drain();
        // high bits of the order word must be ignored, bit 0 clear selects lsb first
        configure(16'h8408, 16'hFFFF, 16'hFFFE);
      end
      push_byte(DIRECTED[i].data, DIRECTED[i].first, DIRECTED[i].last,
                DIRECTED[i].known, DIRECTED[i].crc);
      pace_sender();
    end

    // random phases, extremes of the registers first
    for (int p = 0; p < RAND_PHASES; p++) begin
      drain();
      case (p)
        0: begin poly = 16'h0000; start = 16'hFFFF; order = 16'h0001; end
        1: begin poly = 16'hFFFF; start = 16'h0000; order = 16'h0000; end
        2: begin poly = 16'hFFFF; start = 16'hFFFF; order = 16'hFFFF; end
        3: begin poly = 16'h0000; start = 16'h0000; order = 16'h8000; end
        default: begin
          case ($urandom_range(0, 4))
            0: poly = 16'h1021;
            1: poly = 16'h8408;
            2: poly = 16'h8005;
            3: poly = 16'hA001;
            default: poly = 16'($urandom);
          endcase
          start = 16'($urandom);
          order = 16'($urandom);
        end
      endcase
      configure(poly, start, order);

      sent = 0;
      while (sent < PHASE_BYTES) begin
        if ($urandom_range(0, 99) < 80) begin
          // well-formed message with random content
          len = $urandom_range(1, 12);
          for (int k = 0; k < len; k++) begin
            case ($urandom_range(0, 9))
              0: data = 8'h00;
              1: data = 8'hFF;
              default: data = 8'($urandom);
            endcase
            push_byte(data, k == 0, k == len - 1, 1'b0, 16'h0000);
            pace_sender();
          end
          sent += len;
        end else begin
          // loose byte with random markers
          push_byte(8'($urandom), 1'($urandom), 1'($urandom), 1'b0, 16'h0000);
          pace_sender();
          sent++;
        end
      end
    end

    drain();
    if (mismatch_count == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+rtl/core
rtl/core/crc16cbo_pkg.sv
rtl/core/crc16cbo_fold.sv
rtl/core/crc16_configurable_bit_order_core.sv
rtl/core/crc16cbo_checker.sv
tb/sv/crc16_configurable_bit_order_core_tb.sv
